>>> rtl/core/ssi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths and request, response and queue entry types for the
// segment/segment intersection block.
// ----------------------------------------------------------------------------
package ssi_pkg;

   // Coordinate width. The fraction bits cancel in the quotient and so
   // take no part in any width below.
   localparam int COORD_WIDTH     = 24;
   // x1 - x2 and similar
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   // x1*y2 - y1*x2
   localparam int CROSS_WIDTH     = 2 * COORD_WIDTH + 1;
   // product of two differences
   localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
   // determinant
   localparam int DET_WIDTH       = PROD_WIDTH + 1;
   // cross term times a difference
   localparam int TERM_WIDTH      = PROD_WIDTH + COORD_WIDTH;
   // numerator of either quotient
   localparam int NUM_WIDTH       = TERM_WIDTH + 1;
   // default depth of the queue between front and back
   localparam int DEF_QUEUE_DEPTH = 16;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type seg_a_start_x;
      coord_type seg_a_start_y;
      coord_type seg_a_end_x;
      coord_type seg_a_end_y;
      coord_type seg_b_start_x;
      coord_type seg_b_start_y;
      coord_type seg_b_end_x;
      coord_type seg_b_end_y;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type hit_x;
      coord_type hit_y;
   } rsp_type;

   // One classified request waiting for division
   typedef struct packed {
      logic                        degenerate;
      logic signed [DET_WIDTH-1:0] det;
      logic signed [NUM_WIDTH-1:0] num_x;
      logic signed [NUM_WIDTH-1:0] num_y;
      req_type                     seg;
   } job_type;

endpackage

>>> rtl/core/segment_segment_intersection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_intersection_top
// Line segment intersection by Cramer's rule, signed fixed point.
// ----------------------------------------------------------------------------
// Takes one request (two segments, four endpoints) per clock while req_stall
// is low and returns one response per request, in order: hit, and the
// crossing point truncated toward zero, zeroed on a miss. Six front stages
// build the determinant and numerators, a queue stage follows, then an entry
// stage, a divider that settles one quotient bit per stage after its overflow
// stage, a sign stage and the output register. Sustained rate is one request
// per clock while rsp_stall stays low. req_stall rises only when QUEUE_DEPTH
// requests sit between acceptance and the back pipeline; a depth under about
// eight lets that credit limit, not the pipeline, set the rate.
// ----------------------------------------------------------------------------
module segment_segment_intersection_top #(
   parameter int QUEUE_DEPTH = ssi_pkg::DEF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssi_pkg::rsp_type rsp_data
);
   import ssi_pkg::*;

   localparam int CREDIT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [CREDIT_WIDTH-1:0] used_ff, used_in;
   logic                    req_accept;
   logic                    front_valid;
   job_type                 front_job;
   logic                    queue_valid;
   job_type                 queue_job;
   logic                    queue_pop;

   // Credits: requests taken but not yet popped into the back pipeline
   assign req_stall  = (used_ff == CREDIT_WIDTH'(QUEUE_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign used_in    = used_ff + CREDIT_WIDTH'(req_accept) - CREDIT_WIDTH'(queue_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   ssi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_job   (front_job)
   );

   ssi_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_job),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_job)
   );

   ssi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_job    (queue_job),
      .in_pop    (queue_pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule

>>> rtl/core/ssi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_front
// Front pipeline: forms the determinant and both Cramer numerators and flags
// parallel or degenerate pairs. Six stages, never stalls.
// ----------------------------------------------------------------------------
module ssi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ssi_pkg::req_type in_data,
   output logic             out_valid,
   output ssi_pkg::job_type out_job
);
   import ssi_pkg::*;

   localparam int STAGES = 6;

   logic [STAGES-1:0] valid_ff;

   req_type s0_seg_ff, s1_seg_ff, s2_seg_ff, s3_seg_ff, s4_seg_ff, s5_seg_ff;

   logic signed [DIFF_WIDTH-1:0]    dx12_ff, dy12_ff, dx34_ff, dy34_ff;
   logic signed [DIFF_WIDTH-1:0]    s2_dx12_ff, s2_dy12_ff, s2_dx34_ff, s2_dy34_ff;
   logic signed [2*COORD_WIDTH-1:0] cr_a1_ff, cr_a2_ff, cr_b1_ff, cr_b2_ff;
   logic signed [PROD_WIDTH-1:0]    dm1_ff, dm2_ff;
   logic signed [CROSS_WIDTH-1:0]   pre_ff, post_ff;
   logic signed [DET_WIDTH-1:0]     det_ff, s4_det_ff, s5_det_ff;
   logic signed [PROD_WIDTH-1:0]    pxh1_ff, pxl1_ff, pxh2_ff, pxl2_ff;
   logic signed [PROD_WIDTH-1:0]    pyh1_ff, pyl1_ff, pyh2_ff, pyl2_ff;
   logic signed [TERM_WIDTH-1:0]    tx1_ff, tx2_ff, ty1_ff, ty2_ff;
   logic signed [NUM_WIDTH-1:0]     num_x_ff, num_y_ff;
   logic                            s4_degen_ff, s5_degen_ff;

   logic signed [DIFF_WIDTH-1:0] pre_hi, pre_lo, post_hi, post_lo;

   // Valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   // Stage 0: capture the request
   always_ff @(posedge clock) begin
      s0_seg_ff <= in_data;
   end

   // Stage 1: differences and the four cross products
   always_ff @(posedge clock) begin
      s1_seg_ff <= s0_seg_ff;
      dx12_ff   <= DIFF_WIDTH'(s0_seg_ff.seg_a_start_x) - DIFF_WIDTH'(s0_seg_ff.seg_a_end_x);
      dy12_ff   <= DIFF_WIDTH'(s0_seg_ff.seg_a_start_y) - DIFF_WIDTH'(s0_seg_ff.seg_a_end_y);
      dx34_ff   <= DIFF_WIDTH'(s0_seg_ff.seg_b_start_x) - DIFF_WIDTH'(s0_seg_ff.seg_b_end_x);
      dy34_ff   <= DIFF_WIDTH'(s0_seg_ff.seg_b_start_y) - DIFF_WIDTH'(s0_seg_ff.seg_b_end_y);
      cr_a1_ff  <= s0_seg_ff.seg_a_start_x * s0_seg_ff.seg_a_end_y;
      cr_a2_ff  <= s0_seg_ff.seg_a_start_y * s0_seg_ff.seg_a_end_x;
      cr_b1_ff  <= s0_seg_ff.seg_b_start_x * s0_seg_ff.seg_b_end_y;
      cr_b2_ff  <= s0_seg_ff.seg_b_start_y * s0_seg_ff.seg_b_end_x;
   end

   // Stage 2: determinant products, pre and post cross terms
   always_ff @(posedge clock) begin
      s2_seg_ff  <= s1_seg_ff;
      dm1_ff     <= dx12_ff * dy34_ff;
      dm2_ff     <= dy12_ff * dx34_ff;
      pre_ff     <= CROSS_WIDTH'(cr_a1_ff) - CROSS_WIDTH'(cr_a2_ff);
      post_ff    <= CROSS_WIDTH'(cr_b1_ff) - CROSS_WIDTH'(cr_b2_ff);
      s2_dx12_ff <= dx12_ff;
      s2_dy12_ff <= dy12_ff;
      s2_dx34_ff <= dx34_ff;
      s2_dy34_ff <= dy34_ff;
   end

   // Split cross terms into a signed high and an unsigned low half
   assign pre_hi  = pre_ff[CROSS_WIDTH-1:COORD_WIDTH];
   assign pre_lo  = {1'b0, pre_ff[COORD_WIDTH-1:0]};
   assign post_hi = post_ff[CROSS_WIDTH-1:COORD_WIDTH];
   assign post_lo = {1'b0, post_ff[COORD_WIDTH-1:0]};

   // Stage 3: determinant, partial products of both numerators
   always_ff @(posedge clock) begin
      s3_seg_ff <= s2_seg_ff;
      det_ff    <= DET_WIDTH'(dm1_ff) - DET_WIDTH'(dm2_ff);
      pxh1_ff   <= pre_hi * s2_dx34_ff;
      pxl1_ff   <= pre_lo * s2_dx34_ff;
      pxh2_ff   <= post_hi * s2_dx12_ff;
      pxl2_ff   <= post_lo * s2_dx12_ff;
      pyh1_ff   <= pre_hi * s2_dy34_ff;
      pyl1_ff   <= pre_lo * s2_dy34_ff;
      pyh2_ff   <= post_hi * s2_dy12_ff;
      pyl2_ff   <= post_lo * s2_dy12_ff;
   end

   // Stage 4: recombine the halves, classify
   always_ff @(posedge clock) begin
      s4_seg_ff   <= s3_seg_ff;
      s4_det_ff   <= det_ff;
      s4_degen_ff <= (det_ff == '0);
      tx1_ff      <= (TERM_WIDTH'(pxh1_ff) <<< COORD_WIDTH) + TERM_WIDTH'(pxl1_ff);
      tx2_ff      <= (TERM_WIDTH'(pxh2_ff) <<< COORD_WIDTH) + TERM_WIDTH'(pxl2_ff);
      ty1_ff      <= (TERM_WIDTH'(pyh1_ff) <<< COORD_WIDTH) + TERM_WIDTH'(pyl1_ff);
      ty2_ff      <= (TERM_WIDTH'(pyh2_ff) <<< COORD_WIDTH) + TERM_WIDTH'(pyl2_ff);
   end

   // Stage 5: numerators
   always_ff @(posedge clock) begin
      s5_seg_ff   <= s4_seg_ff;
      s5_det_ff   <= s4_det_ff;
      s5_degen_ff <= s4_degen_ff;
      num_x_ff    <= NUM_WIDTH'(tx1_ff) - NUM_WIDTH'(tx2_ff);
      num_y_ff    <= NUM_WIDTH'(ty1_ff) - NUM_WIDTH'(ty2_ff);
   end

   assign out_valid          = valid_ff[STAGES-1];
   assign out_job.degenerate = s5_degen_ff;
   assign out_job.det        = s5_det_ff;
   assign out_job.num_x      = num_x_ff;
   assign out_job.num_y      = num_y_ff;
   assign out_job.seg        = s5_seg_ff;

endmodule

>>> rtl/core/ssi_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_fifo
// Register queue between front and back. The top level's credit count keeps
// it from overfilling. Depth of two or more.
// ----------------------------------------------------------------------------
module ssi_fifo #(
   parameter int DEPTH = ssi_pkg::DEF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssi_pkg::job_type push_data,
   input  logic             pop,
   output logic             pop_valid,
   output ssi_pkg::job_type pop_data
);
   import ssi_pkg::*;

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   job_type              mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0] count_ff;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

endmodule

>>> rtl/core/ssi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_div
// Pipelined restoring divider on magnitudes. One overflow stage tests whether
// the quotient needs more than COORD_WIDTH bits, then one stage per quotient
// bit. Every stage advances only while enable is high.
// ----------------------------------------------------------------------------
module ssi_div (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [ssi_pkg::NUM_WIDTH-1:0]    num_mag,
   input  logic [ssi_pkg::DET_WIDTH-1:0]    den_mag,
   output logic [ssi_pkg::COORD_WIDTH-1:0]  quo,
   output logic                             overflow
);
   import ssi_pkg::*;

   logic [NUM_WIDTH-1:0]   rem_ff [COORD_WIDTH];
   logic [DET_WIDTH-1:0]   den_ff [COORD_WIDTH];
   logic [COORD_WIDTH-1:0] quo_ff [COORD_WIDTH+1];
   logic                   ovf_ff [COORD_WIDTH+1];

   // Overflow stage: quotient magnitude of 2^COORD_WIDTH or more is a miss
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num_mag;
         den_ff[0] <= den_mag;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (num_mag >= (NUM_WIDTH'(den_mag) << COORD_WIDTH));
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar k = 1; k <= COORD_WIDTH; k++) begin : g_stage
      logic [NUM_WIDTH-1:0] shifted;
      logic                 ge;

      assign shifted = NUM_WIDTH'(den_ff[k-1]) << (COORD_WIDTH - k);
      assign ge      = (rem_ff[k-1] >= shifted);

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k] <= {quo_ff[k-1][COORD_WIDTH-2:0], ge};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end

      if (k < COORD_WIDTH) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= ge ? rem_ff[k-1] - shifted : rem_ff[k-1];
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign quo      = quo_ff[COORD_WIDTH];
   assign overflow = ovf_ff[COORD_WIDTH];

endmodule

>>> rtl/core/ssi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_back
// Back pipeline: takes queued requests, divides both numerators by the
// determinant, restores signs, tests the point against both segments'
// bounding ranges and holds the response in an output register. The whole
// pipeline advances whenever the output register is free or being taken.
// ----------------------------------------------------------------------------
module ssi_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ssi_pkg::job_type in_job,
   output logic             in_pop,
   output logic             out_valid,
   output ssi_pkg::rsp_type out_data,
   input  logic             out_stall
);
   import ssi_pkg::*;

   localparam int LANE_DEPTH = COORD_WIDTH + 1;

   typedef struct packed {
      logic      degenerate;
      logic      neg_x;
      logic      neg_y;
      coord_type x_lo;
      coord_type x_hi;
      coord_type y_lo;
      coord_type y_hi;
   } side_type;

   logic back_en;

   logic                   b0_valid_ff;
   logic [NUM_WIDTH-1:0]   b0_nx_ff, b0_ny_ff;
   logic [DET_WIDTH-1:0]   b0_d_ff;
   logic                   b0_negx_ff, b0_negy_ff, b0_degen_ff;
   coord_type              ax_lo_ff, ax_hi_ff, bx_lo_ff, bx_hi_ff;
   coord_type              ay_lo_ff, ay_hi_ff, by_lo_ff, by_hi_ff;

   logic [LANE_DEPTH-1:0]  lane_valid_ff;
   side_type               side_ff [LANE_DEPTH];
   side_type               side_in;
   side_type               side_out;

   logic [COORD_WIDTH-1:0] qx_mag, qy_mag;
   logic                   ovf_x, ovf_y;
   logic signed [COORD_WIDTH:0] qx_pos, qy_pos;

   logic                   sg_valid_ff, sg_miss_ff;
   logic signed [COORD_WIDTH:0] qx_ff, qy_ff;
   coord_type              sg_x_lo_ff, sg_x_hi_ff, sg_y_lo_ff, sg_y_hi_ff;

   logic                   x_ok, y_ok, hit;
   logic                   out_valid_ff;
   rsp_type                out_data_ff;

   // Pipeline advance and queue pop
   assign back_en = !out_valid_ff || !out_stall;
   assign in_pop  = in_valid && back_en;

   // Entry stage: magnitudes, quotient signs, per-segment bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
      end else if (back_en) begin
         b0_valid_ff <= in_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         b0_nx_ff    <= in_job.num_x[NUM_WIDTH-1] ? NUM_WIDTH'(-in_job.num_x)
                                                  : NUM_WIDTH'(in_job.num_x);
         b0_ny_ff    <= in_job.num_y[NUM_WIDTH-1] ? NUM_WIDTH'(-in_job.num_y)
                                                  : NUM_WIDTH'(in_job.num_y);
         b0_d_ff     <= in_job.det[DET_WIDTH-1] ? DET_WIDTH'(-in_job.det)
                                                : DET_WIDTH'(in_job.det);
         b0_negx_ff  <= in_job.num_x[NUM_WIDTH-1] ^ in_job.det[DET_WIDTH-1];
         b0_negy_ff  <= in_job.num_y[NUM_WIDTH-1] ^ in_job.det[DET_WIDTH-1];
         b0_degen_ff <= in_job.degenerate;
         ax_lo_ff <= (in_job.seg.seg_a_start_x < in_job.seg.seg_a_end_x)
                     ? in_job.seg.seg_a_start_x : in_job.seg.seg_a_end_x;
         ax_hi_ff <= (in_job.seg.seg_a_start_x < in_job.seg.seg_a_end_x)
                     ? in_job.seg.seg_a_end_x : in_job.seg.seg_a_start_x;
         bx_lo_ff <= (in_job.seg.seg_b_start_x < in_job.seg.seg_b_end_x)
                     ? in_job.seg.seg_b_start_x : in_job.seg.seg_b_end_x;
         bx_hi_ff <= (in_job.seg.seg_b_start_x < in_job.seg.seg_b_end_x)
                     ? in_job.seg.seg_b_end_x : in_job.seg.seg_b_start_x;
         ay_lo_ff <= (in_job.seg.seg_a_start_y < in_job.seg.seg_a_end_y)
                     ? in_job.seg.seg_a_start_y : in_job.seg.seg_a_end_y;
         ay_hi_ff <= (in_job.seg.seg_a_start_y < in_job.seg.seg_a_end_y)
                     ? in_job.seg.seg_a_end_y : in_job.seg.seg_a_start_y;
         by_lo_ff <= (in_job.seg.seg_b_start_y < in_job.seg.seg_b_end_y)
                     ? in_job.seg.seg_b_start_y : in_job.seg.seg_b_end_y;
         by_hi_ff <= (in_job.seg.seg_b_start_y < in_job.seg.seg_b_end_y)
                     ? in_job.seg.seg_b_end_y : in_job.seg.seg_b_start_y;
      end
   end

   // Divider lanes
   ssi_div u_div_x (
      .clock    (clock),
      .enable   (back_en),
      .num_mag  (b0_nx_ff),
      .den_mag  (b0_d_ff),
      .quo      (qx_mag),
      .overflow (ovf_x)
   );

   ssi_div u_div_y (
      .clock    (clock),
      .enable   (back_en),
      .num_mag  (b0_ny_ff),
      .den_mag  (b0_d_ff),
      .quo      (qy_mag),
      .overflow (ovf_y)
   );

   // Sideband alongside the dividers; common range of both segments
   always_comb begin
      side_in.degenerate = b0_degen_ff;
      side_in.neg_x      = b0_negx_ff;
      side_in.neg_y      = b0_negy_ff;
      side_in.x_lo       = (ax_lo_ff > bx_lo_ff) ? ax_lo_ff : bx_lo_ff;
      side_in.x_hi       = (ax_hi_ff < bx_hi_ff) ? ax_hi_ff : bx_hi_ff;
      side_in.y_lo       = (ay_lo_ff > by_lo_ff) ? ay_lo_ff : by_lo_ff;
      side_in.y_hi       = (ay_hi_ff < by_hi_ff) ? ay_hi_ff : by_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= '0;
      end else if (back_en) begin
         lane_valid_ff <= {lane_valid_ff[LANE_DEPTH-2:0], b0_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 1; k < LANE_DEPTH; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (back_en) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign side_out = side_ff[LANE_DEPTH-1];

   // Sign stage
   assign qx_pos = signed'({1'b0, qx_mag});
   assign qy_pos = signed'({1'b0, qy_mag});

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_valid_ff <= 1'b0;
      end else if (back_en) begin
         sg_valid_ff <= lane_valid_ff[LANE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         qx_ff      <= side_out.neg_x ? -qx_pos : qx_pos;
         qy_ff      <= side_out.neg_y ? -qy_pos : qy_pos;
         sg_miss_ff <= side_out.degenerate || ovf_x || ovf_y;
         sg_x_lo_ff <= side_out.x_lo;
         sg_x_hi_ff <= side_out.x_hi;
         sg_y_lo_ff <= side_out.y_lo;
         sg_y_hi_ff <= side_out.y_hi;
      end
   end

   // Range test, inclusive on both ends
   assign x_ok = (qx_ff >= (COORD_WIDTH+1)'(sg_x_lo_ff)) &&
                 (qx_ff <= (COORD_WIDTH+1)'(sg_x_hi_ff));
   assign y_ok = (qy_ff >= (COORD_WIDTH+1)'(sg_y_lo_ff)) &&
                 (qy_ff <= (COORD_WIDTH+1)'(sg_y_hi_ff));
   assign hit  = !sg_miss_ff && x_ok && y_ok;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (back_en) begin
         out_valid_ff <= sg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         out_data_ff.hit   <= hit;
         out_data_ff.hit_x <= hit ? qx_ff[COORD_WIDTH-1:0] : '0;
         out_data_ff.hit_y <= hit ? qy_ff[COORD_WIDTH-1:0] : '0;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

>>> rtl/core/ssi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_checker
// Port-level checks on the intersection block, bound to the top level.
// ----------------------------------------------------------------------------
module ssi_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ssi_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ssi_pkg::rsp_type rsp_data
);
   import ssi_pkg::*;

   logic [15:0] pending_ff;
   logic        req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // Requests taken and not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 16'(req_acc) - 16'(rsp_acc);
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.hit_x == '0 && rsp_data.hit_y == '0)
      else $error("miss carries a nonzero point");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pending_ff != '0)
      else $error("response without a pending request");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> pending_ff != '0)
      else $error("request stalled while nothing is pending");

endmodule

bind segment_segment_intersection_top ssi_checker u_ssi_checker (.*);
